/* src/sapm_pkg.sv */
// Shared types and constants for the stereo anaglyph pixel mixer.
// Holds the coefficient format, the preset weight word and the register index codes.
// No dependencies.
package sapm_pkg;

  // Coefficient and pixel format
  localparam int COEFF_FRAC_BITS = 14;
  localparam int PIX_W           = 8;
  localparam int COEF_W          = 16;
  localparam int NUM_CH          = 3;
  localparam int NUM_REGS        = 2 * NUM_CH;
  localparam int REG_W           = NUM_CH * COEF_W;
  localparam int IDX_W           = 3;
  localparam int PIX_MAX         = (1 << PIX_W) - 1;

  // Signed coefficient times zero-extended pixel, then sums of three and of six
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int SUM_W  = PROD_W + 3;

  // Luma weights rounded to the coefficient grid
  localparam logic [COEF_W-1:0] LUMA_R =
    COEF_W'((299 * (1 << COEFF_FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] LUMA_G =
    COEF_W'((587 * (1 << COEFF_FRAC_BITS) + 500) / 1000);
  localparam logic [COEF_W-1:0] LUMA_B =
    COEF_W'((114 * (1 << COEFF_FRAC_BITS) + 500) / 1000);
  localparam logic [REG_W-1:0] LUMA_WORD = {LUMA_R, LUMA_G, LUMA_B};

  // Half an output step, added before the final shift
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (COEFF_FRAC_BITS - 1));

  // Coefficient register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_LEFT_RED,
    REG_LEFT_GREEN,
    REG_LEFT_BLUE,
    REG_RIGHT_RED,
    REG_RIGHT_GREEN,
    REG_RIGHT_BLUE
  } coef_reg_t;

  // Pick coefficient k (0 = red weight at the top) out of a packed row
  function automatic logic signed [COEF_W-1:0] coeff_at(input logic [REG_W-1:0] row,
                                                        input int k);
    coeff_at = $signed(row[REG_W-1-k*COEF_W -: COEF_W]);
  endfunction

endpackage

/* src/stereo_anaglyph_pixel_mixer.sv */
// Throughput one word per cycle while out_stall is low; stalls back up to in_stall.
// Stages: 18 coefficient-by-pixel products, row sums of three, channel sum with round/clamp.
// Each stage advances when it is empty or the next one moves, so bubbles collapse.
// Reset (rst_n low, synchronous) clears all valid bits and loads the true-anaglyph preset.
// Top level of the stereo anaglyph pixel mixer; depends on sapm_pkg.
module stereo_anaglyph_pixel_mixer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sapm_pkg::PIX_W-1:0]    in_left_red,
  input  logic [sapm_pkg::PIX_W-1:0]    in_left_green,
  input  logic [sapm_pkg::PIX_W-1:0]    in_left_blue,
  input  logic [sapm_pkg::PIX_W-1:0]    in_right_red,
  input  logic [sapm_pkg::PIX_W-1:0]    in_right_green,
  input  logic [sapm_pkg::PIX_W-1:0]    in_right_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sapm_pkg::PIX_W-1:0]    out_red,
  output logic [sapm_pkg::PIX_W-1:0]    out_green,
  output logic [sapm_pkg::PIX_W-1:0]    out_blue,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sapm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sapm_pkg::REG_W-1:0]    cfg_data
);
  import sapm_pkg::*;

  logic [REG_W-1:0]          coef_r [NUM_REGS];
  logic [PIX_W-1:0]          left_px [NUM_CH];
  logic [PIX_W-1:0]          right_px [NUM_CH];

  logic                      s1_valid_r;
  logic signed [PROD_W-1:0]  prod_r   [NUM_CH][NUM_REGS];
  logic signed [PROD_W-1:0]  prod_nxt [NUM_CH][NUM_REGS];

  logic                      s2_valid_r;
  logic signed [SUM_W-1:0]   left_sum_r    [NUM_CH];
  logic signed [SUM_W-1:0]   right_sum_r   [NUM_CH];
  logic signed [SUM_W-1:0]   left_sum_nxt  [NUM_CH];
  logic signed [SUM_W-1:0]   right_sum_nxt [NUM_CH];

  logic                      out_valid_r;
  logic [PIX_W-1:0]          out_px_r   [NUM_CH];
  logic [PIX_W-1:0]          out_px_nxt [NUM_CH];

  logic                      adv1, adv2, adv3;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  // Coefficient registers, preset on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= '0;
      end
      coef_r[REG_LEFT_RED]   <= LUMA_WORD;
      coef_r[REG_RIGHT_BLUE] <= LUMA_WORD;
    end else if (cfg_valid && (cfg_index < IDX_W'(NUM_REGS))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // Advance a stage when it is empty or its successor moves
  assign adv3     = !out_valid_r || !out_stall;
  assign adv2     = !s2_valid_r || adv3;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  assign left_px[0]  = in_left_red;
  assign left_px[1]  = in_left_green;
  assign left_px[2]  = in_left_blue;
  assign right_px[0] = in_right_red;
  assign right_px[1] = in_right_green;
  assign right_px[2] = in_right_blue;

  // Stage 1: every coefficient times its pixel component
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        prod_nxt[ch][k] = coeff_at(coef_r[ch], k) * $signed({1'b0, left_px[k]});
        prod_nxt[ch][NUM_CH+k] =
          coeff_at(coef_r[NUM_CH+ch], k) * $signed({1'b0, right_px[k]});
      end
    end
  end

  // Stage 2: row sums, rounding offset folded into the left row
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      left_sum_nxt[ch]  = SUM_W'(prod_r[ch][0]) + SUM_W'(prod_r[ch][1]) +
                          SUM_W'(prod_r[ch][2]) + ROUND_HALF;
      right_sum_nxt[ch] = SUM_W'(prod_r[ch][NUM_CH]) + SUM_W'(prod_r[ch][NUM_CH+1]) +
                          SUM_W'(prod_r[ch][NUM_CH+2]);
    end
  end

  // Stage 3: channel sum, drop the fraction, clamp to pixel range
  always_comb begin
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] q;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total = left_sum_r[ch] + right_sum_r[ch];
      q     = total >>> COEFF_FRAC_BITS;
      if (total < 0) begin
        out_px_nxt[ch] = '0;
      end else if (q > SUM_W'(PIX_MAX)) begin
        out_px_nxt[ch] = PIX_W'(PIX_MAX);
      end else begin
        out_px_nxt[ch] = q[PIX_W-1:0];
      end
    end
  end

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_valid;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload registers, held while their stage is stalled
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (adv2 && s1_valid_r) begin
      left_sum_r  <= left_sum_nxt;
      right_sum_r <= right_sum_nxt;
    end
    if (adv3 && s2_valid_r) begin
      out_px_r <= out_px_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_px_r[0];
  assign out_green = out_px_r[1];
  assign out_blue  = out_px_r[2];

endmodule

/* src/sapm_checker.sv */
// Port-level checks for the stereo anaglyph pixel mixer, bound to the top level.
// Depends on sapm_pkg for port widths.
module sapm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sapm_pkg::PIX_W-1:0]  out_red,
  input logic [sapm_pkg::PIX_W-1:0]  out_green,
  input logic [sapm_pkg::PIX_W-1:0]  out_blue
);
  import sapm_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A free output side never backs up the input
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // An accepted word reaches out_valid when the output keeps draining
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing three cycles after accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed");

endmodule

bind stereo_anaglyph_pixel_mixer sapm_checker u_sapm_checker (.*);
